/* src/crcbr_pkg.sv */
package crcbr_pkg;

  // Session limits and checksum constants
  localparam int unsigned MAX_PAGE  = 32768;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_MSB   = 16'h8000;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT   = 1'b1;

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Result queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_CHK_LO,
    PH_CHK_HI,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_ACCEPT   = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_END      = 3'd3,
    KIND_TOO_BIG  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] flash_address;
    logic [15:0] block_length;
    logic        last;
  } result_t;

  // Results produced by one accepted beat: count and up to two entries
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } frame_out_t;

  // CRC-16, MSB first, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/crcbr_frame.sv */
module crcbr_frame (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     cmd,
  input  logic [7:0]               rx_byte,
  input  logic [31:0]              start_offset,
  input  logic [15:0]              page_limit,
  output crcbr_pkg::frame_out_t    fout
);

  crcbr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] chk_r, chk_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [31:0] wofs_r, wofs_nxt;

  logic [15:0] limit;
  logic [15:0] crc_upd;
  logic [15:0] cnt_inc;
  logic [31:0] byte_addr;
  logic [15:0] hdr_len;
  logic        blk_done;

  // Shared datapath terms
  always_comb begin
    limit     = (page_limit > 16'(crcbr_pkg::MAX_PAGE)) ? 16'(crcbr_pkg::MAX_PAGE) : page_limit;
    crc_upd   = crcbr_pkg::crc16_byte(crc_r, rx_byte);
    cnt_inc   = cnt_r + 16'd1;
    byte_addr = wofs_r + {16'd0, cnt_r};
    hdr_len   = len_r;
    blk_done  = (cnt_inc == len_r);
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (cmd == crcbr_pkg::CMD_START) begin
        phase_nxt = crcbr_pkg::PH_LEN_LO;
      end else begin
        case (phase_r)
          crcbr_pkg::PH_LEN_LO: phase_nxt = crcbr_pkg::PH_LEN_HI;
          crcbr_pkg::PH_LEN_HI: phase_nxt = crcbr_pkg::PH_CHK_LO;
          crcbr_pkg::PH_CHK_LO: phase_nxt = crcbr_pkg::PH_CHK_HI;
          crcbr_pkg::PH_CHK_HI: begin
            if (hdr_len == 16'd0 || hdr_len > limit) begin
              phase_nxt = crcbr_pkg::PH_DONE;
            end else begin
              phase_nxt = crcbr_pkg::PH_DATA;
            end
          end
          crcbr_pkg::PH_DATA: begin
            if (blk_done) begin
              phase_nxt = crcbr_pkg::PH_LEN_LO;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Header, checksum and offset updates plus results for this beat
  always_comb begin
    len_nxt  = len_r;
    chk_nxt  = chk_r;
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    wofs_nxt = wofs_r;
    fout     = '0;
    if (accept) begin
      if (cmd == crcbr_pkg::CMD_START) begin
        wofs_nxt = start_offset;
        len_nxt  = 16'd0;
        chk_nxt  = 16'd0;
        crc_nxt  = crcbr_pkg::CRC_INIT;
        cnt_nxt  = 16'd0;
      end else begin
        case (phase_r)
          crcbr_pkg::PH_LEN_LO: len_nxt = {8'h00, rx_byte};
          crcbr_pkg::PH_LEN_HI: len_nxt = {rx_byte, len_r[7:0]};
          crcbr_pkg::PH_CHK_LO: chk_nxt = {8'h00, rx_byte};
          crcbr_pkg::PH_CHK_HI: begin
            chk_nxt = {rx_byte, chk_r[7:0]};
            if (hdr_len == 16'd0) begin
              fout.cnt                = 2'd1;
              fout.res0.kind          = crcbr_pkg::KIND_END;
              fout.res0.flash_address = wofs_r;
              fout.res0.last          = 1'b1;
            end else if (hdr_len > limit) begin
              fout.cnt                = 2'd1;
              fout.res0.kind          = crcbr_pkg::KIND_TOO_BIG;
              fout.res0.flash_address = wofs_r;
              fout.res0.block_length  = hdr_len;
              fout.res0.last          = 1'b1;
            end else begin
              crc_nxt = crcbr_pkg::CRC_INIT;
              cnt_nxt = 16'd0;
            end
          end
          crcbr_pkg::PH_DATA: begin
            crc_nxt                 = crc_upd;
            cnt_nxt                 = cnt_inc;
            fout.res0.kind          = crcbr_pkg::KIND_PAYLOAD;
            fout.res0.data_byte     = rx_byte;
            fout.res0.flash_address = byte_addr;
            if (!blk_done) begin
              fout.cnt       = 2'd1;
              fout.res0.last = 1'b1;
            end else begin
              // Last payload byte: append the verdict
              fout.cnt                = 2'd2;
              cnt_nxt                 = 16'd0;
              fout.res1.flash_address = wofs_r;
              fout.res1.block_length  = len_r;
              fout.res1.last          = 1'b1;
              if (crc_upd == chk_r) begin
                fout.res1.kind = crcbr_pkg::KIND_ACCEPT;
                wofs_nxt       = wofs_r + {16'd0, len_r};
              end else begin
                fout.res1.kind = crcbr_pkg::KIND_MISMATCH;
              end
            end
          end
          default: begin
            // Bytes outside a session are dropped
            fout.cnt = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crcbr_pkg::PH_DONE;
      len_r   <= 16'd0;
      chk_r   <= 16'd0;
      crc_r   <= crcbr_pkg::CRC_INIT;
      cnt_r   <= 16'd0;
      wofs_r  <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      chk_r   <= chk_nxt;
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      wofs_r  <= wofs_nxt;
    end
  end

endmodule

/* src/crcbr_out_fifo.sv */
module crcbr_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crcbr_pkg::frame_out_t fout,
  input  logic                  pop,
  output logic                  room2,
  output logic                  head_valid,
  output crcbr_pkg::result_t    head
);

  crcbr_pkg::result_t                mem [crcbr_pkg::QDEPTH];
  logic [crcbr_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [crcbr_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [crcbr_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic [crcbr_pkg::QPTR_W-1:0]      wr_ptr_p1;

  // Status seen by the input and output sides
  assign room2      = (count_r <= crcbr_pkg::QCNT_W'(crcbr_pkg::QDEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + crcbr_pkg::QPTR_W'(fout.cnt);
    rd_ptr_nxt = rd_ptr_r + crcbr_pkg::QPTR_W'(pop);
    count_nxt  = count_r + crcbr_pkg::QCNT_W'(fout.cnt) - crcbr_pkg::QCNT_W'(pop);
  end

  // Store the beat's results
  always_ff @(posedge clk) begin
    if (fout.cnt != 2'd0) begin
      mem[wr_ptr_r] <= fout.res0;
    end
    if (fout.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= fout.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/crc_checked_block_upload_receiver.sv */
// Framed block upload receiver: takes one beat per clock unless stalled (cmd 0 starts
// a session from start_offset, cmd 1 carries a stream byte), parses the little-endian
// length and CRC-16 header, forwards each payload byte with its flash address and
// gives an accept, mismatch, session-end or too-large verdict. The header parser and
// the one-byte CRC update sit in a single stage, so an input beat is taken every cycle
// that in_stall is low and its results go straight into a four-entry result queue;
// the first result can be read in the cycle after its input beat. The last payload
// byte of a block yields two results; in_stall rises while the queue holds three or
// more results. With an output that never stalls the queue holds at most two results,
// since the next header yields none before its last beat, so the input never stalls.
module crc_checked_block_upload_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_flash_address,
  output logic [15:0] out_block_length,
  output logic        out_last
);

  logic [31:0] start_offset_r;
  logic [15:0] page_limit_r;

  logic                  in_accept;
  logic                  room2;
  logic                  pop;
  crcbr_pkg::frame_out_t fout;
  crcbr_pkg::result_t    head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= 32'd0;
      page_limit_r   <= 16'(crcbr_pkg::MAX_PAGE);
    end else if (cfg_we) begin
      case (cfg_index)
        crcbr_pkg::REG_START_OFFSET: start_offset_r <= cfg_data;
        crcbr_pkg::REG_PAGE_LIMIT:   page_limit_r   <= cfg_data[15:0];
        default:                     start_offset_r <= start_offset_r;
      endcase
    end
  end

  // Handshakes
  assign in_stall  = !room2;
  assign in_accept = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  crcbr_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .cmd          (in_cmd),
    .rx_byte      (in_rx_byte),
    .start_offset (start_offset_r),
    .page_limit   (page_limit_r),
    .fout         (fout)
  );

  crcbr_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .fout       (fout),
    .pop        (pop),
    .room2      (room2),
    .head_valid (out_valid),
    .head       (head)
  );

  // Drive the result beat from the queue head
  assign out_kind          = head.kind;
  assign out_data_byte     = head.data_byte;
  assign out_flash_address = head.flash_address;
  assign out_block_length  = head.block_length;
  assign out_last          = head.last;

endmodule
